// File: rtl/core/tae_pkg.sv
// ============================================================================
// tae_pkg: shared types and constants of the Thumb-to-ARM expander
// Format codes, handler classes, pipeline stage records and the table of
// fixed bits for register-offset loads and stores.
// ============================================================================
package tae_pkg;

    // Condition field of every expanded ARM word that is not a branch, and the default branch
    // condition for words that are not conditional branches.
    localparam logic [3:0]  COND_AL    = 4'hE;
    // Permanently undefined ARM encoding.
    localparam logic [31:0] UNDEF_WORD = 32'hE7F0_00F0;

    // Handler classes.
    localparam logic [3:0] K_DP_REG     = 4'd0;
    localparam logic [3:0] K_DP_IMM     = 4'd1;
    localparam logic [3:0] K_MUL        = 4'd2;
    localparam logic [3:0] K_BX         = 4'd3;
    localparam logic [3:0] K_LDST_IMM   = 4'd4;
    localparam logic [3:0] K_LDST_REG   = 4'd5;
    localparam logic [3:0] K_HALF_REG   = 4'd6;
    localparam logic [3:0] K_SIGNED_REG = 4'd7;
    localparam logic [3:0] K_HALF_IMM   = 4'd8;
    localparam logic [3:0] K_MULTIPLE   = 4'd9;
    localparam logic [3:0] K_SWI        = 4'd10;
    localparam logic [3:0] K_UNDEF      = 4'd11;
    localparam logic [3:0] K_BCOND      = 4'd12;
    localparam logic [3:0] K_B          = 4'd13;
    localparam logic [3:0] K_BL_PREFIX  = 4'd14;
    localparam logic [3:0] K_BL_SUFFIX  = 4'd15;

    // Register ALU opcodes (Thumb format 4) that need their own expansion.
    localparam logic [3:0] ALU_LSL = 4'd2;
    localparam logic [3:0] ALU_LSR = 4'd3;
    localparam logic [3:0] ALU_ASR = 4'd4;
    localparam logic [3:0] ALU_ROR = 4'd7;
    localparam logic [3:0] ALU_TST = 4'd8;
    localparam logic [3:0] ALU_NEG = 4'd9;
    localparam logic [3:0] ALU_CMP = 4'd10;
    localparam logic [3:0] ALU_CMN = 4'd11;
    localparam logic [3:0] ALU_MUL = 4'd13;
    localparam logic [3:0] ALU_MVN = 4'd15;

    // Hi-register operation codes.
    localparam logic [1:0] HI_ADD = 2'd0;
    localparam logic [1:0] HI_CMP = 2'd1;
    localparam logic [1:0] HI_MOV = 2'd2;
    localparam logic [1:0] HI_BX  = 2'd3;

    // Instruction formats found by the first stage.
    typedef enum logic [4:0] {
        F_SHIFT,
        F_ADDSUB,
        F_IMM8,
        F_ALU,
        F_HI,
        F_LIT,
        F_LDST_REG,
        F_LDST_IMM,
        F_HALF,
        F_SP_LDST,
        F_ADDR,
        F_SP_ADJ,
        F_PUSHPOP,
        F_LDM,
        F_SWI,
        F_BCOND,
        F_B,
        F_BL_HI,
        F_BL_LO,
        F_UNDEF
    } t_fmt;

    // Record after format decode.
    typedef struct packed {
        logic [15:0] half;
        t_fmt        fmt;
    } t_dec;

    // Record after word expansion.
    typedef struct packed {
        logic [15:0] half;
        t_fmt        fmt;
        logic [31:0] word;
        logic [3:0]  kind;
        logic        unp;
    } t_exp;

    // Opcode byte (bits 27:20) and bits 7:4 of a register-offset load or store.
    function automatic logic [11:0] ldst_reg_fix(input logic [2:0] opc);
        logic [11:0] fix;
        unique case (opc)
            3'd0: fix = {8'h78, 4'h0};
            3'd1: fix = {8'h18, 4'hB};
            3'd2: fix = {8'h7C, 4'h0};
            3'd3: fix = {8'h19, 4'hD};
            3'd4: fix = {8'h79, 4'h0};
            3'd5: fix = {8'h19, 4'hB};
            3'd6: fix = {8'h7D, 4'h0};
            default: fix = {8'h19, 4'hF};
        endcase
        return fix;
    endfunction

endpackage

// File: rtl/core/tae_expand.sv
// ============================================================================
// tae_expand: ARM word builder
// Builds the 32-bit ARM word, the handler class and the unpredictable flag
// of one decoded Thumb instruction.
// ============================================================================
module tae_expand
    import tae_pkg::*;
(
    input  t_dec  i_dec,
    output t_exp  o_exp
);

    logic [15:0] h;
    logic [3:0]  r0, r3, r6, r8, rm, rdn;
    logic [4:0]  imm5;
    logic [7:0]  imm8;
    logic [3:0]  opc_as;
    logic [3:0]  alu_op;
    logic [1:0]  hi_op;
    logic [11:0] fix;
    logic [31:0] w;
    logic [3:0]  kind;
    logic        unp;

    assign h      = i_dec.half;
    assign r0     = {1'b0, h[2:0]};
    assign r3     = {1'b0, h[5:3]};
    assign r6     = {1'b0, h[8:6]};
    assign r8     = {1'b0, h[10:8]};
    assign rm     = h[6:3];
    assign rdn    = {h[7], h[2:0]};
    assign imm5   = h[10:6];
    assign imm8   = h[7:0];
    assign opc_as = h[9] ? 4'd2 : 4'd4;
    assign alu_op = h[9:6];
    assign hi_op  = h[9:8];
    assign fix    = ldst_reg_fix(h[11:9]);

    always_comb begin
        w    = '0;
        kind = K_UNDEF;
        unp  = 1'b0;
        unique case (i_dec.fmt)
            F_SHIFT: begin
                w    = {COND_AL, 8'h1B, 4'h0, r0, imm5, h[12:11], 1'b0, r3};
                kind = K_DP_REG;
            end
            F_ADDSUB: begin
                w    = {COND_AL, 2'b00, h[10], opc_as, 1'b1, r3, r0, 8'h00, r6};
                kind = h[10] ? K_DP_IMM : K_DP_REG;
            end
            F_IMM8: begin
                kind = K_DP_IMM;
                unique case (h[12:11])
                    2'd0: w = {COND_AL, 8'h3B, 4'h0, r8, 4'h0, imm8};
                    2'd1: w = {COND_AL, 8'h35, r8, 4'h0, 4'h0, imm8};
                    2'd2: w = {COND_AL, 8'h29, r8, r8, 4'h0, imm8};
                    default: w = {COND_AL, 8'h25, r8, r8, 4'h0, imm8};
                endcase
            end
            F_ALU: begin
                kind = K_DP_REG;
                unique case (alu_op)
                    ALU_MUL: begin
                        w    = {COND_AL, 8'h01, r0, 4'h0, r0, 4'h9, r3};
                        kind = K_MUL;
                    end
                    ALU_NEG: begin
                        w    = {COND_AL, 8'h27, r3, r0, 12'h000};
                        kind = K_DP_IMM;
                    end
                    ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: begin
                        // Shift by register: MOV Rd, Rd, <shift> Rs.
                        w = {COND_AL, 8'h1B, 4'h0, r0, r3, 1'b0,
                             (alu_op == ALU_ROR) ? 2'd3 : (alu_op[1:0] - 2'd2), 1'b1, r0};
                    end
                    ALU_TST, ALU_CMP, ALU_CMN, ALU_MVN: begin
                        if (alu_op == ALU_MVN) begin
                            w = {COND_AL, 3'b000, alu_op, 1'b1, 4'h0, r0, 8'h00, r3};
                        end else begin
                            w = {COND_AL, 3'b000, alu_op, 1'b1, r0, 4'h0, 8'h00, r3};
                        end
                    end
                    default: begin
                        // AND, EOR, ADC, SBC, ORR, BIC keep their opcode number.
                        w = {COND_AL, 3'b000, alu_op, 1'b1, r0, r0, 8'h00, r3};
                    end
                endcase
            end
            F_HI: begin
                unique case (hi_op)
                    HI_BX: begin
                        w    = {COND_AL, 8'h12, 12'hFFF, 4'h1, rm};
                        kind = K_BX;
                        unp  = h[7] | (h[2:0] != 3'd0);
                    end
                    HI_ADD: begin
                        w    = {COND_AL, 8'h08, rdn, rdn, 8'h00, rm};
                        kind = K_DP_REG;
                        unp  = ~h[6] & ~h[7];
                    end
                    HI_CMP: begin
                        w    = {COND_AL, 8'h15, rdn, 4'h0, 8'h00, rm};
                        kind = K_DP_REG;
                        unp  = ~h[6] & ~h[7];
                    end
                    default: begin
                        w    = {COND_AL, 8'h1A, 4'h0, rdn, 8'h00, rm};
                        kind = K_DP_REG;
                        unp  = ~h[6] & ~h[7];
                    end
                endcase
            end
            F_LIT: begin
                w    = {COND_AL, 8'h59, 4'hF, r8, 2'b00, imm8, 2'b00};
                kind = K_LDST_IMM;
            end
            F_LDST_REG: begin
                w = {COND_AL, fix[11:4], r3, r0, 4'h0, fix[3:0], r6};
                if (h[10:9] == 2'd1) begin
                    kind = K_HALF_REG;
                end else if (h[10:9] == 2'd3) begin
                    kind = K_SIGNED_REG;
                end else begin
                    kind = K_LDST_REG;
                end
            end
            F_LDST_IMM: begin
                w = {COND_AL, 5'b01011, h[12], 1'b0, h[11], r3, r0,
                     h[12] ? {7'd0, imm5} : {5'd0, imm5, 2'b00}};
                kind = K_LDST_IMM;
            end
            F_HALF: begin
                w = {COND_AL, 7'b0001110, h[11], r3, r0, 2'b00, imm5[4:3], 4'hB,
                     imm5[2:0], 1'b0};
                kind = K_HALF_IMM;
            end
            F_SP_LDST: begin
                w    = {COND_AL, 7'b0101100, h[11], 4'hD, r8, 2'b00, imm8, 2'b00};
                kind = K_LDST_IMM;
            end
            F_ADDR: begin
                w    = {COND_AL, 8'h28, h[11] ? 4'hD : 4'hF, r8, 4'hF, imm8};
                kind = K_DP_IMM;
            end
            F_SP_ADJ: begin
                w    = {COND_AL, 8'h20 | {3'b000, h[7] ? 4'd2 : 4'd4, 1'b0}, 4'hD, 4'hD,
                        4'hF, 1'b0, h[6:0]};
                kind = K_DP_IMM;
            end
            F_PUSHPOP: begin
                if (h[11]) begin
                    w = {COND_AL, 8'h8B, 4'hD, h[8], 7'd0, imm8};
                end else begin
                    w = {COND_AL, 8'h92, 4'hD, 1'b0, h[8], 6'd0, imm8};
                end
                kind = K_MULTIPLE;
            end
            F_LDM: begin
                w    = {COND_AL, 7'b1000101, h[11], r8, 8'h00, imm8};
                kind = K_MULTIPLE;
            end
            F_SWI: begin
                w    = {COND_AL, 8'hF0, 12'h000, imm8};
                kind = K_SWI;
            end
            F_BCOND:  kind = K_BCOND;
            F_B:      kind = K_B;
            F_BL_HI:  kind = K_BL_PREFIX;
            F_BL_LO:  kind = K_BL_SUFFIX;
            default: begin
                w    = UNDEF_WORD;
                kind = K_UNDEF;
                unp  = 1'b1;
            end
        endcase
    end

    assign o_exp.half = i_dec.half;
    assign o_exp.fmt  = i_dec.fmt;
    assign o_exp.word = w;
    assign o_exp.kind = kind;
    assign o_exp.unp  = unp;

endmodule

// File: rtl/core/thumb_to_arm_instruction_expander_top.sv
// ============================================================================
// thumb_to_arm_instruction_expander_top: ARMv4T Thumb instruction expander
// Three-stage pipeline that turns one 16-bit Thumb instruction into its
// 32-bit ARM equivalent plus handler class and branch information.
// ============================================================================
// Each input word carries one Thumb halfword; each output word carries the
// expanded ARM instruction (condition always), the handler class, and for the
// branch classes the scaled signed offset and condition. Branch classes give
// an ARM word of zero, and undefined encodings give the permanently undefined
// ARM word with the unpredictable flag set. The block takes one instruction
// per clock while the output side is not stalled, and each result passes
// through the three registered stages in order: stage one classifies the format, stage two
// builds the ARM word, stage three forms the branch fields and holds the
// result for the output port. Every stage holds its own valid bit and advances
// whenever the stage after it is empty or moving, so a stall on the output
// side backs up without loss and the full rate resumes as soon as the output
// is taken again.
module thumb_to_arm_instruction_expander_top
    import tae_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] thumb_halfword
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [31:0] arm_word, [35:32] handler_kind, [58:36] branch_offset,
    // [62:59] branch_cond, [63] unpredictable
    output logic [63:0] o_m_tdata
);

    // Stage valid bits and handshake chain. A stage may load when it is empty
    // or when the stage after it is also advancing.
    logic r_v1, r_v2, r_v3;
    logic n_v1, n_v2, n_v3;
    logic rdy1, rdy2, rdy3;

    assign rdy3       = ~r_v3 | i_m_tready;
    assign rdy2       = ~r_v2 | rdy3;
    assign rdy1       = ~r_v1 | rdy2;
    assign o_s_tready = rdy1;

    assign n_v1 = rdy1 ? i_s_tvalid : r_v1;
    assign n_v2 = rdy2 ? r_v1       : r_v2;
    assign n_v3 = rdy3 ? r_v2       : r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    // ------------------------------------------------------------------
    // Stage one: format decode from the top bits of the halfword.
    // ------------------------------------------------------------------
    logic [15:0] in_half;
    t_fmt        dec_fmt;
    t_dec        r_dec, n_dec;

    assign in_half = i_s_tdata;

    always_comb begin
        dec_fmt = F_UNDEF;
        unique case (in_half[15:11])
            5'd0, 5'd1, 5'd2:       dec_fmt = F_SHIFT;
            5'd3:                   dec_fmt = F_ADDSUB;
            5'd4, 5'd5, 5'd6, 5'd7: dec_fmt = F_IMM8;
            5'd8:                   dec_fmt = in_half[10] ? F_HI : F_ALU;
            5'd9:                   dec_fmt = F_LIT;
            5'd10, 5'd11:           dec_fmt = F_LDST_REG;
            5'd12, 5'd13, 5'd14, 5'd15: dec_fmt = F_LDST_IMM;
            5'd16, 5'd17:           dec_fmt = F_HALF;
            5'd18, 5'd19:           dec_fmt = F_SP_LDST;
            5'd20, 5'd21:           dec_fmt = F_ADDR;
            5'd22, 5'd23: begin
                // Only SP adjust and push/pop are defined in the miscellaneous space.
                if (in_half[11:8] == 4'd0) begin
                    dec_fmt = F_SP_ADJ;
                end else if (in_half[10:9] == 2'b10) begin
                    dec_fmt = F_PUSHPOP;
                end else begin
                    dec_fmt = F_UNDEF;
                end
            end
            5'd24, 5'd25:           dec_fmt = F_LDM;
            5'd26, 5'd27: begin
                if (in_half[11:8] == 4'hF) begin
                    dec_fmt = F_SWI;
                end else if (in_half[11:8] == 4'hE) begin
                    dec_fmt = F_UNDEF;
                end else begin
                    dec_fmt = F_BCOND;
                end
            end
            5'd28:                  dec_fmt = F_B;
            5'd30:                  dec_fmt = F_BL_HI;
            5'd31:                  dec_fmt = F_BL_LO;
            default:                dec_fmt = F_UNDEF;
        endcase
    end

    assign n_dec = '{half: in_half, fmt: dec_fmt};

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_dec <= n_dec;
        end
    end

    // ------------------------------------------------------------------
    // Stage two: ARM word, handler class and unpredictable flag.
    // ------------------------------------------------------------------
    t_exp r_exp, n_exp;

    tae_expand u_expand (
        .i_dec (r_dec),
        .o_exp (n_exp)
    );

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_exp <= n_exp;
        end
    end

    // ------------------------------------------------------------------
    // Stage three: branch offset and condition, then the output register.
    // ------------------------------------------------------------------
    logic [15:0] bh;
    logic [22:0] br_off;
    logic [3:0]  br_cond;
    logic [63:0] r_out, n_out;

    assign bh = r_exp.half;

    always_comb begin
        br_off  = '0;
        br_cond = COND_AL;
        unique case (r_exp.fmt)
            F_BCOND: begin
                br_off  = {{14{bh[7]}}, bh[7:0], 1'b0};
                br_cond = bh[11:8];
            end
            F_B:     br_off = {{11{bh[10]}}, bh[10:0], 1'b0};
            F_BL_HI: br_off = {bh[10:0], 12'h000};
            F_BL_LO: br_off = {11'd0, bh[10:0], 1'b0};
            default: br_off = '0;
        endcase
    end

    assign n_out = {r_exp.unp, br_cond, br_off, r_exp.kind, r_exp.word};

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = r_out;

endmodule
